FILE: sv/ntbu_pkg.sv
`timescale 1ns / 1ps
package ntbu_pkg;

	localparam int NEURONS   = 1024;
	localparam int NEURON_W  = 10;
	// entries above the reach of the neuron field can never be addressed
	localparam int MEM_DEPTH = (NEURONS < (1 << NEURON_W)) ? NEURONS : (1 << NEURON_W);
	localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	localparam int TRACE_W   = 24;
	localparam int VAL_W     = 32;
	localparam int GAIN_W    = 24;
	localparam int LOG_STEPS = 20;
	localparam int X_W       = TRACE_W + 1;
	localparam int K_W       = $clog2(X_W);
	localparam int MANT_W    = 31;
	localparam int LG_W      = K_W + 1 + LOG_STEPS;

	localparam int FIFO_DEPTH = 32;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [29:0] LN2_Q30 = 30'd744261118;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_P_RATE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_E_RATE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Z_RATE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CUR_DECAY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPIKE_INC   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_GAIN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_EPS   = 3'd6;

	localparam logic signed [GAIN_W-1:0] BIAS_GAIN_RST = 24'sd65536;

	typedef logic [TRACE_W-1:0] trace_t;

	typedef struct packed {
		logic [NEURON_W-1:0]     neuron;
		logic                    spike;
		logic signed [VAL_W-1:0] current_in;
	} item_t;

	typedef struct packed {
		logic [NEURON_W-1:0]     neuron_out;
		logic signed [VAL_W-1:0] bias;
		logic signed [VAL_W-1:0] current_out;
		trace_t                  p_value;
	} result_t;

	typedef struct packed {
		trace_t                   p_rate;
		trace_t                   e_rate;
		trace_t                   z_rate;
		trace_t                   current_decay;
		trace_t                   spike_increment;
		logic signed [GAIN_W-1:0] bias_gain;
		trace_t                   floor_eps;
	} cfg_t;

	typedef struct packed {
		trace_t p;
		trace_t e;
		trace_t z;
	} traces_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		traces_t           tr;
	} trace_wr_t;

	typedef struct packed {
		logic                    en;
		logic [ADDR_W-1:0]       addr;
		logic signed [VAL_W-1:0] bias;
	} bias_wr_t;

	typedef struct packed {
		logic                    in_range;
		logic [NEURON_W-1:0]     neuron;
		logic signed [VAL_W-1:0] current;
		trace_t                  p;
		logic signed [VAL_W-1:0] bias_old;
	} side_t;

	function automatic trace_t clamp_trace(input logic signed [TRACE_W+2:0] v);
		trace_t r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({3'b000, {TRACE_W{1'b1}}})) begin
			r = '1;
		end else begin
			r = v[TRACE_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: sv/ntbu_state_mem.sv
`timescale 1ns / 1ps
module ntbu_state_mem import ntbu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rd_en,
	input  logic [ADDR_W-1:0]       rd_addr,
	output traces_t                 rd_tr,
	output logic signed [VAL_W-1:0] rd_bias,
	input  trace_wr_t               tr_wr,
	input  bias_wr_t                bias_wr,
	output logic                    clearing
);

	traces_t                 trace_mem [MEM_DEPTH];
	logic signed [VAL_W-1:0] bias_mem  [MEM_DEPTH];

	logic              clear_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// zero both memories one entry per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
				clear_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// read-first: a read at the write address returns the old entry
	always_ff @(posedge clk) begin
		if (clear_q) begin
			trace_mem[clr_addr_q] <= '0;
		end else if (tr_wr.en) begin
			trace_mem[tr_wr.addr] <= tr_wr.tr;
		end
		if (rd_en) begin
			rd_tr <= trace_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (clear_q) begin
			bias_mem[clr_addr_q] <= '0;
		end else if (bias_wr.en) begin
			bias_mem[bias_wr.addr] <= bias_wr.bias;
		end
		if (rd_en) begin
			rd_bias <= bias_mem[rd_addr];
		end
	end

	assign clearing = clear_q;

endmodule

FILE: sv/ntbu_trace.sv
`timescale 1ns / 1ps
module ntbu_trace import ntbu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    accept,
	input  item_t                   item,
	input  traces_t                 rd_tr,
	input  logic signed [VAL_W-1:0] rd_bias,
	output trace_wr_t               tr_wr,
	output logic                    side_valid,
	output side_t                   side
);

	localparam int DP_W = 2 * TRACE_W + 2;
	localparam int ZP_W = 2 * TRACE_W + 1;
	localparam int CP_W = VAL_W + TRACE_W + 2;
	localparam int NW   = TRACE_W + 3;
	localparam int HALF = 1 << (TRACE_W - 1);

	// stage 1: memory data arrives
	logic                    valid_s1;
	logic                    inr_s1;
	logic [NEURON_W-1:0]     neuron_s1;
	logic                    spike_s1;
	logic signed [VAL_W-1:0] cur_s1;

	// stage 2: products
	logic                    valid_s2;
	logic                    inr_s2;
	logic [NEURON_W-1:0]     neuron_s2;
	logic                    spike_s2;
	logic signed [DP_W-1:0]  dp_prod_s2;
	logic signed [DP_W-1:0]  de_prod_s2;
	logic [ZP_W-1:0]         z_prod_s2;
	logic signed [CP_W-1:0]  cur_prod_s2;
	trace_t                  p_s2;
	trace_t                  e_s2;
	logic signed [VAL_W-1:0] bias_s2;

	// stage 3: written traces
	logic                    valid_s3;
	logic                    inr_s3;
	logic [NEURON_W-1:0]     neuron_s3;
	traces_t                 tr_s3;
	logic signed [VAL_W-1:0] cur_s3;
	logic signed [VAL_W-1:0] bias_s3;

	logic    hit2, hit3;
	traces_t cur_tr;
	traces_t new_tr;
	logic    item_inr;

	logic signed [TRACE_W:0] pe_diff, ez_diff;
	logic [TRACE_W:0]        z_keep, cur_keep;
	logic signed [DP_W-1:0]  dp_prod, de_prod;
	logic [ZP_W-1:0]         z_prod;
	logic signed [CP_W-1:0]  cur_prod;

	logic signed [DP_W-1:0]         dp_sum, de_sum;
	logic signed [DP_W-TRACE_W-1:0] dp_rnd, de_rnd;
	logic signed [NW-1:0]           np_wide, ne_wide;
	logic [ZP_W-1:0]                z_sum;
	logic [ZP_W-TRACE_W-1:0]        z_rnd;
	logic [NW-1:0]                  nz_wide;
	logic signed [CP_W-1:0]         cur_sum;
	logic signed [VAL_W-1:0]        cur_out;

	assign item_inr = ({1'b0, item.neuron} < (NEURON_W + 1)'(MEM_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// a same-neuron transaction one or two slots ahead has not reached the memory yet
	always_comb begin
		hit2 = valid_s2 && inr_s2 && (neuron_s2 == neuron_s1);
		hit3 = valid_s3 && inr_s3 && (neuron_s3 == neuron_s1);
		priority if (hit2) begin
			cur_tr = new_tr;
		end else if (hit3) begin
			cur_tr = tr_s3;
		end else begin
			cur_tr = rd_tr;
		end
	end

	always_comb begin
		pe_diff  = $signed({1'b0, cur_tr.e}) - $signed({1'b0, cur_tr.p});
		ez_diff  = $signed({1'b0, cur_tr.z}) - $signed({1'b0, cur_tr.e});
		z_keep   = {1'b1, {TRACE_W{1'b0}}} - {1'b0, cfg.z_rate};
		cur_keep = {1'b1, {TRACE_W{1'b0}}} - {1'b0, cfg.current_decay};
		dp_prod  = pe_diff * $signed({1'b0, cfg.p_rate});
		de_prod  = ez_diff * $signed({1'b0, cfg.e_rate});
		z_prod   = cur_tr.z * z_keep;
		cur_prod = cur_s1 * $signed({1'b0, cur_keep});
	end

	// round to nearest, ties up: add half then arithmetic shift
	always_comb begin
		dp_sum   = dp_prod_s2 + DP_W'(HALF);
		de_sum   = de_prod_s2 + DP_W'(HALF);
		dp_rnd   = dp_sum[DP_W-1:TRACE_W];
		de_rnd   = de_sum[DP_W-1:TRACE_W];
		np_wide  = $signed({3'b000, p_s2}) + NW'(dp_rnd);
		ne_wide  = $signed({3'b000, e_s2}) + NW'(de_rnd);
		z_sum    = z_prod_s2 + ZP_W'(HALF);
		z_rnd    = z_sum[ZP_W-1:TRACE_W];
		nz_wide  = {2'b00, z_rnd} + (spike_s2 ? {3'b000, cfg.spike_increment} : NW'(0));
		cur_sum  = cur_prod_s2 + CP_W'(HALF);
		cur_out  = cur_sum[VAL_W+TRACE_W-1:TRACE_W];
		new_tr.p = clamp_trace(np_wide);
		new_tr.e = clamp_trace(ne_wide);
		new_tr.z = clamp_trace($signed(nz_wide));
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			inr_s1    <= item_inr;
			neuron_s1 <= item.neuron;
			spike_s1  <= item.spike;
			cur_s1    <= item.current_in;
		end
		inr_s2      <= inr_s1;
		neuron_s2   <= neuron_s1;
		spike_s2    <= spike_s1;
		dp_prod_s2  <= dp_prod;
		de_prod_s2  <= de_prod;
		z_prod_s2   <= z_prod;
		cur_prod_s2 <= cur_prod;
		p_s2        <= cur_tr.p;
		e_s2        <= cur_tr.e;
		bias_s2     <= rd_bias;
		inr_s3      <= inr_s2;
		neuron_s3   <= neuron_s2;
		tr_s3       <= new_tr;
		cur_s3      <= cur_out;
		bias_s3     <= bias_s2;
	end

	assign tr_wr.en   = valid_s2 && inr_s2;
	assign tr_wr.addr = neuron_s2[ADDR_W-1:0];
	assign tr_wr.tr   = new_tr;

	assign side_valid    = valid_s3;
	assign side.in_range = inr_s3;
	assign side.neuron   = neuron_s3;
	assign side.current  = cur_s3;
	assign side.p        = tr_s3.p;
	assign side.bias_old = bias_s3;

endmodule

FILE: sv/ntbu_log.sv
`timescale 1ns / 1ps
module ntbu_log import ntbu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     side_valid,
	input  side_t    side,
	output logic     res_valid,
	output result_t  res,
	output bias_wr_t bias_wr
);

	localparam int ST_X  = 4;
	localparam int ST_K  = 5;
	localparam int ST_M  = 6;
	localparam int ST_LG = ST_M + LOG_STEPS;
	localparam int ST_PL = ST_LG + 1;
	localparam int ST_LN = ST_PL + 1;
	localparam int ST_PB = ST_LN + 1;
	localparam int PL_W  = LG_W + 31;
	localparam int PB_W  = GAIN_W + LG_W;

	logic                    vld_s  [ST_X:ST_PB];
	side_t                   side_s [ST_X:ST_PB];
	logic                    zero_s [ST_K:ST_PB];
	logic [K_W-1:0]          k_s    [ST_K:ST_LG];
	logic [MANT_W-1:0]       mant_s [ST_M:ST_LG];
	logic [LOG_STEPS-1:0]    frac_s [ST_M:ST_LG];
	logic [X_W-1:0]          x_s4;
	logic [X_W-1:0]          x_s5;
	logic signed [PL_W-1:0]  prod_ln_s27;
	logic signed [LG_W-1:0]  ln_s28;
	logic signed [PB_W-1:0]  prod_b_s29;

	logic [K_W-1:0]          lead;
	logic [K_W-1:0]          shamt;
	logic signed [K_W:0]     int_part;
	logic signed [LG_W-1:0]  lg;
	logic signed [PL_W-1:0]  ln_sum;
	logic signed [PB_W-1:0]  b_sum;
	logic signed [PB_W-LOG_STEPS-1:0] b_rnd;
	logic signed [VAL_W-1:0] bias_calc;
	logic signed [VAL_W-1:0] bias_out;
	logic                    p_on;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = ST_X; i <= ST_PB; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			vld_s[ST_X] <= side_valid;
			for (int i = ST_X + 1; i <= ST_PB; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// msb position of x
	always_comb begin
		lead = '0;
		for (int b = 0; b < X_W; b++) begin
			if (x_s4[b]) begin
				lead = K_W'(b);
			end
		end
	end

	assign shamt = K_W'(MANT_W - 1) - k_s[ST_K];

	always_ff @(posedge clk) begin
		side_s[ST_X] <= side;
		for (int i = ST_X + 1; i <= ST_PB; i++) begin
			side_s[i] <= side_s[i-1];
		end
		x_s4          <= {1'b0, side.p} + {1'b0, cfg.floor_eps};
		x_s5          <= x_s4;
		zero_s[ST_K]  <= (x_s4 == '0);
		for (int i = ST_K + 1; i <= ST_PB; i++) begin
			zero_s[i] <= zero_s[i-1];
		end
		k_s[ST_K]     <= lead;
		for (int i = ST_K + 1; i <= ST_LG; i++) begin
			k_s[i] <= k_s[i-1];
		end
		// mantissa in Q1.30
		mant_s[ST_M]  <= MANT_W'(x_s5) << shamt;
		frac_s[ST_M]  <= '0;
	end

	// one fraction bit of log2 per stage: square, halve when it reaches two
	for (genvar j = ST_M; j < ST_LG; j++) begin : g_sq
		logic [2*MANT_W-1:0] sq;
		logic [MANT_W:0]     sq_hi;
		assign sq    = mant_s[j] * mant_s[j];
		assign sq_hi = sq[2*MANT_W-1:MANT_W-1];
		always_ff @(posedge clk) begin
			mant_s[j+1] <= sq_hi[MANT_W] ? sq_hi[MANT_W:1] : sq_hi[MANT_W-1:0];
			frac_s[j+1] <= {frac_s[j][LOG_STEPS-2:0], sq_hi[MANT_W]};
		end
	end

	always_comb begin
		int_part = $signed({1'b0, k_s[ST_LG]}) - (K_W + 1)'(TRACE_W);
		lg       = $signed({int_part, frac_s[ST_LG]});
		ln_sum   = prod_ln_s27 + PL_W'(1 << 29);
		b_sum    = prod_b_s29 + PB_W'(1 << (LOG_STEPS - 1));
		b_rnd    = b_sum[PB_W-1:LOG_STEPS];
		// |gain * ln| stays far below the 32-bit limit, so no saturation is needed
		bias_calc = VAL_W'(b_rnd);
	end

	always_ff @(posedge clk) begin
		prod_ln_s27 <= lg * $signed({1'b0, LN2_Q30});
		ln_s28      <= ln_sum[LG_W+29:30];
		prod_b_s29  <= cfg.bias_gain * ln_s28;
	end

	assign p_on = (cfg.p_rate != '0);

	always_comb begin
		priority if (!side_s[ST_PB].in_range) begin
			bias_out = '0;
		end else if (!p_on) begin
			bias_out = side_s[ST_PB].bias_old;
		end else if (zero_s[ST_PB]) begin
			// log of zero: pinned to the rail opposite the gain sign
			priority if (cfg.bias_gain > 0) begin
				bias_out = {1'b1, {(VAL_W-1){1'b0}}};
			end else if (cfg.bias_gain < 0) begin
				bias_out = {1'b0, {(VAL_W-1){1'b1}}};
			end else begin
				bias_out = '0;
			end
		end else begin
			bias_out = bias_calc;
		end
	end

	assign res_valid       = vld_s[ST_PB];
	assign res.neuron_out  = side_s[ST_PB].neuron;
	assign res.bias        = bias_out;
	assign res.current_out = side_s[ST_PB].current;
	assign res.p_value     = side_s[ST_PB].in_range ? side_s[ST_PB].p : '0;

	assign bias_wr.en   = vld_s[ST_PB] && side_s[ST_PB].in_range && p_on;
	assign bias_wr.addr = side_s[ST_PB].neuron[ADDR_W-1:0];
	assign bias_wr.bias = bias_out;

endmodule

FILE: sv/ntbu_out_fifo.sv
`timescale 1ns / 1ps
module ntbu_out_fifo import ntbu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t din,
	output logic    valid,
	input  logic    stall,
	output result_t dout
);

	result_t            slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               pop;

	assign valid = (cnt_q != '0);
	assign pop   = valid && !stall;
	assign dout  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= din;
		end
	end

endmodule

FILE: sv/neuron_trace_bias_update.sv
`timescale 1ns / 1ps
// Per-neuron trace and bias update.
// item channel (item_valid / item_stall / item): one transaction names a neuron, its
//   spike flag and its synaptic current. result channel (result_valid / result_stall /
//   result): one transaction per item, in order, with the decayed current, the new p
//   trace and the new or kept bias. cfg channel (cfg_valid / cfg_ready, always ready):
//   writes the rate, gain and floor registers; write only while the block is idle.
// Throughput: one item per cycle while item_stall is low, also for back-to-back items
//   of one neuron (the trace memory read-modify-write forwards from two stages ahead).
// Path: between the item being taken and result_valid lie the trace memory read, the
//   trace stages, the 20-stage log2 squaring chain, the multiply stages and the queue.
// Up to 32 items may be outstanding; results wait in a 32-entry queue while
//   result_stall is high, and item_stall rises once 32 items are outstanding.
// Reset: registers return to defaults (bias gain 1.0) and the trace and bias memories
//   are swept to zero one entry per cycle; item_stall stays high while the sweep runs.
module neuron_trace_bias_update import ntbu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TRACE_W-1:0]   cfg_data
);

	cfg_t             cfg_q;
	logic [FIFO_AW:0] outstanding_q;
	logic             accept;
	logic             deliver;
	logic             clearing;

	traces_t                 rd_tr;
	logic signed [VAL_W-1:0] rd_bias;
	trace_wr_t               tr_wr;
	bias_wr_t                bias_wr;
	logic                    side_valid;
	side_t                   side;
	logic                    res_valid;
	result_t                 res;

	assign cfg_ready  = 1'b1;
	assign item_stall = clearing || (outstanding_q == (FIFO_AW + 1)'(FIFO_DEPTH));
	assign accept     = item_valid && !item_stall;
	assign deliver    = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.p_rate          <= '0;
			cfg_q.e_rate          <= '0;
			cfg_q.z_rate          <= '0;
			cfg_q.current_decay   <= '0;
			cfg_q.spike_increment <= '0;
			cfg_q.bias_gain       <= BIAS_GAIN_RST;
			cfg_q.floor_eps       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_P_RATE:    cfg_q.p_rate          <= cfg_data;
				REG_E_RATE:    cfg_q.e_rate          <= cfg_data;
				REG_Z_RATE:    cfg_q.z_rate          <= cfg_data;
				REG_CUR_DECAY: cfg_q.current_decay   <= cfg_data;
				REG_SPIKE_INC: cfg_q.spike_increment <= cfg_data;
				REG_BIAS_GAIN: cfg_q.bias_gain       <= $signed(cfg_data);
				REG_FLOOR_EPS: cfg_q.floor_eps       <= cfg_data;
				default: ;
			endcase
		end
	end

	// items in the pipeline plus results in the queue never exceed the queue depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + (FIFO_AW + 1)'(accept) - (FIFO_AW + 1)'(deliver);
		end
	end

	ntbu_state_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (item.neuron[ADDR_W-1:0]),
		.rd_tr    (rd_tr),
		.rd_bias  (rd_bias),
		.tr_wr    (tr_wr),
		.bias_wr  (bias_wr),
		.clearing (clearing)
	);

	ntbu_trace u_trace (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.item       (item),
		.rd_tr      (rd_tr),
		.rd_bias    (rd_bias),
		.tr_wr      (tr_wr),
		.side_valid (side_valid),
		.side       (side)
	);

	ntbu_log u_log (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.side_valid (side_valid),
		.side       (side),
		.res_valid  (res_valid),
		.res        (res),
		.bias_wr    (bias_wr)
	);

	ntbu_out_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.din    (res),
		.valid  (result_valid),
		.stall  (result_stall),
		.dout   (result)
	);

endmodule
